// ----- sv/mscp_pkg.sv -----
// ----------------------------------------------------------------------------
// mscp_pkg
// Shared types and constants for the system control coprocessor.
// ----------------------------------------------------------------------------
package mscp_pkg;

    localparam int REGISTER_COUNT_DEF = 32;

    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_TICK      = 3'd2;
    localparam logic [2:0] CMD_EXCEPTION = 3'd3;
    localparam logic [2:0] CMD_RFE       = 3'd4;
    localparam logic [2:0] CMD_ERET      = 3'd5;

    localparam logic [4:0] R_RANDOM   = 5'd1;
    localparam logic [4:0] R_BADVADDR = 5'd8;
    localparam logic [4:0] R_COUNT    = 5'd9;
    localparam logic [4:0] R_COMPARE  = 5'd11;
    localparam logic [4:0] R_STATUS   = 5'd12;
    localparam logic [4:0] R_CAUSE    = 5'd13;
    localparam logic [4:0] R_EPC      = 5'd14;
    localparam logic [4:0] R_PRID     = 5'd15;
    localparam logic [4:0] R_CONFIG   = 5'd16;
    localparam logic [4:0] R_ERROREPC = 5'd30;

    localparam logic [4:0] EXC_MOD  = 5'd1;
    localparam logic [4:0] EXC_ADES = 5'd5;

    localparam logic [31:0] STATUS_WR_MASK = 32'hFFFC_FFFF;
    localparam logic [31:0] STATUS_KEEP    = 32'h0003_0000;
    localparam logic [31:0] CAUSE_WR_MASK  = 32'h0000_0300;
    localparam logic [31:0] CAUSE_TI       = 32'h0000_8000;
    localparam logic [31:0] CAUSE_EXC_MASK = 32'h0000_007C;
    localparam logic [31:0] VEC_BEV        = 32'hBFC0_0200;
    localparam logic [31:0] VEC_NORMAL     = 32'h8000_0000;
    localparam logic [31:0] ST_BEV         = 32'h0040_0000;
    localparam logic [31:0] ST_ERL         = 32'h0000_0004;
    localparam logic [31:0] ST_EXL         = 32'h0000_0002;
    localparam logic [31:0] ST_IE          = 32'h0000_0001;

    localparam logic [31:0] RST_PRID    = 32'h0000_2700;
    localparam logic [31:0] RST_CONFIG  = 32'h0006_E463;
    localparam logic [31:0] RST_STATUS  = 32'h0040_0000;
    localparam logic [31:0] RST_COMPARE = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_RANDOM  = 32'd63;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  register_index;
        logic [31:0] write_data;
        logic [31:0] tick_count;
        logic [4:0]  exception_code;
        logic [31:0] current_pc;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] new_pc;
        logic        pc_valid;
        logic [7:0]  pending_irq;
    } t_out_beat;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctl;

endpackage

// ----- sv/mscp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mscp_ctrl
// Handshake controller: holds one command and the result register state.
// ----------------------------------------------------------------------------
module mscp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output mscp_pkg::t_ctl o_ctl
);
    import mscp_pkg::*;

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_HELD  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic execute, capture;

    assign execute    = (r_state == S_HELD) & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = (r_state == S_HELD) & ~execute;
    assign capture    = i_in_valid & ~o_in_stall;

    always_comb begin
        case (r_state)
            S_EMPTY: n_state = capture ? S_HELD : S_EMPTY;
            S_HELD:  n_state = (capture | ~execute) ? S_HELD : S_EMPTY;
            default: n_state = S_EMPTY;
        endcase
        n_out_valid = execute | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ctl.capture = capture;
    assign o_ctl.execute = execute;

endmodule

// ----- sv/mscp_datapath.sv -----
// ----------------------------------------------------------------------------
// mscp_datapath
// Register file, command execution and result register.
// ----------------------------------------------------------------------------
module mscp_datapath #(
    parameter int REGISTER_COUNT = mscp_pkg::REGISTER_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mscp_pkg::t_ctl      i_ctl,
    input  mscp_pkg::t_in_beat  i_in_beat,
    output mscp_pkg::t_out_beat o_out_beat
);
    import mscp_pkg::*;

    localparam int IW = $clog2(REGISTER_COUNT);

    function automatic logic [31:0] reset_value(input logic [IW-1:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx == IW'(R_PRID))    v = RST_PRID;
        if (idx == IW'(R_CONFIG))  v = RST_CONFIG;
        if (idx == IW'(R_STATUS))  v = RST_STATUS;
        if (idx == IW'(R_COMPARE)) v = RST_COMPARE;
        if (idx == IW'(R_RANDOM))  v = RST_RANDOM;
        return v;
    endfunction

    t_in_beat    r_item;
    logic [31:0] r_regs [REGISTER_COUNT];
    logic [31:0] n_regs [REGISTER_COUNT];
    t_out_beat   r_out, n_out;

    logic [IW-1:0] idx;
    logic [31:0]   st, cause, new_count;
    logic [31:0]   n_status, n_cause;

    assign idx       = r_item.register_index[IW-1:0];
    assign st        = r_regs[IW'(R_STATUS)];
    assign cause     = r_regs[IW'(R_CAUSE)];
    assign new_count = r_regs[IW'(R_COUNT)] + r_item.tick_count;

    always_comb begin
        n_regs          = r_regs;
        n_out.read_data = '0;
        n_out.new_pc    = '0;
        n_out.pc_valid  = 1'b0;
        case (r_item.command)
            CMD_READ: n_out.read_data = r_regs[idx];
            CMD_WRITE: begin
                if (idx == IW'(R_STATUS)) begin
                    n_regs[idx] = (r_item.write_data & STATUS_WR_MASK) | (st & STATUS_KEEP);
                end else if (idx == IW'(R_CAUSE)) begin
                    n_regs[idx] = (cause & ~CAUSE_WR_MASK)
                                | (r_item.write_data & CAUSE_WR_MASK);
                end else if (idx != IW'(R_PRID) && idx != IW'(R_CONFIG)) begin
                    n_regs[idx] = r_item.write_data;
                end
            end
            CMD_TICK: begin
                n_regs[IW'(R_COUNT)] = new_count;
                if (new_count >= r_regs[IW'(R_COMPARE)]) begin
                    n_regs[IW'(R_CAUSE)] = cause | CAUSE_TI;
                end
            end
            CMD_EXCEPTION: begin
                if ((st & ST_EXL) != '0) begin
                    n_regs[IW'(R_ERROREPC)] = r_item.current_pc;
                end else begin
                    n_regs[IW'(R_EPC)] = r_item.current_pc;
                end
                n_regs[IW'(R_STATUS)] = st | ST_EXL;
                n_regs[IW'(R_CAUSE)]  = (cause & ~CAUSE_EXC_MASK)
                                      | {25'd0, r_item.exception_code, 2'b00};
                if (r_item.exception_code >= EXC_MOD && r_item.exception_code <= EXC_ADES) begin
                    n_regs[IW'(R_BADVADDR)] = r_item.current_pc;
                end
                n_out.new_pc   = (((st & ST_BEV) != '0) ? VEC_BEV : VEC_NORMAL)
                               + {20'd0, r_item.exception_code, 7'd0};
                n_out.pc_valid = 1'b1;
            end
            CMD_RFE: n_regs[IW'(R_STATUS)] = st & ~ST_EXL;
            CMD_ERET: begin
                if ((st & ST_ERL) != '0) begin
                    n_out.new_pc          = r_regs[IW'(R_ERROREPC)];
                    n_regs[IW'(R_STATUS)] = st & ~ST_ERL;
                end else begin
                    n_out.new_pc          = r_regs[IW'(R_EPC)];
                    n_regs[IW'(R_STATUS)] = st & ~ST_EXL;
                end
                n_out.pc_valid = 1'b1;
            end
            default: ;
        endcase
        n_status = n_regs[IW'(R_STATUS)];
        n_cause  = n_regs[IW'(R_CAUSE)];
        n_out.pending_irq = ((n_status & ST_IE) != '0) ? (n_cause[15:8] & n_status[15:8])
                                                       : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= reset_value(IW'(i));
            end
        end else if (i_ctl.execute) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item <= i_in_beat;
        end
        if (i_ctl.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out_beat = r_out;

endmodule

// ----- sv/mips_system_coprocessor.sv -----
// ----------------------------------------------------------------------------
// mips_system_coprocessor
// An accepted command is registered, then executed into the result register.
// Throughput: one command per cycle; the command register and the result
// register execute and drain in step while the output is not stalled.
// Reset: synchronous active low; registers load their architectural reset
// values (PRId, Config, Status with BEV, Compare, Random; others zero).
// ----------------------------------------------------------------------------
module mips_system_coprocessor #(
    parameter int REGISTER_COUNT = mscp_pkg::REGISTER_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mscp_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mscp_pkg::t_out_beat o_out_beat
);
    import mscp_pkg::*;

    t_ctl ctl;

    mscp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl)
    );

    mscp_datapath #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_in_beat  (i_in_beat),
        .o_out_beat (o_out_beat)
    );

endmodule

// ----- verif/tb_mips_system_coprocessor.sv -----
// ----------------------------------------------------------------------------
// tb_mips_system_coprocessor
// Self-checking bench for the system control coprocessor: a directed command
// sequence, then random command beats over several idle/stall phases. A local
// copy of the CP0 register file predicts every result beat, and the monitor
// compares each accepted beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mips_system_coprocessor;
    timeunit 1ns;
    timeprecision 1ps;

    import mscp_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [4:0] EXC_ADEL     = 5'd4;
    localparam logic [4:0] REG_LAST     = 5'd31;
    localparam int         PHASE_COUNT  = 5;
    localparam int         PHASE_BEATS  = 390;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 500000;

    localparam logic [4:0] NAMED_REGS [10] = '{R_RANDOM, R_BADVADDR, R_COUNT, R_COMPARE,
        R_STATUS, R_CAUSE, R_EPC, R_PRID, R_CONFIG, R_ERROREPC};
    localparam int IDLE_PCT  [PHASE_COUNT] = '{0, 75, 0, 38, 0};
    localparam int STALL_PCT [PHASE_COUNT] = '{0, 0, 75, 38, 0};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    t_in_beat    pending_cmds[$];
    t_out_beat   expected_results[$];
    logic [31:0] cp0_regs [32];
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    logic        hold_arm     = 1'b0;
    logic        hold_arm_q   = 1'b0;
    int          hold_cnt     = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;

    mips_system_coprocessor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_beat make_cmd(input logic [2:0] cmd, input logic [4:0] idx,
                                          input logic [31:0] wdata, input logic [31:0] ticks,
                                          input logic [4:0] code, input logic [31:0] pc);
        t_in_beat b;
        b.command        = cmd;
        b.register_index = idx;
        b.write_data     = wdata;
        b.tick_count     = ticks;
        b.exception_code = code;
        b.current_pc     = pc;
        return b;
    endfunction

    function automatic t_in_beat random_cmd();
        t_in_beat b;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            b.command = CMD_READ;
        end else if (pick < 55) begin
            b.command = CMD_WRITE;
        end else if (pick < 70) begin
            b.command = CMD_TICK;
        end else if (pick < 85) begin
            b.command = CMD_EXCEPTION;
        end else if (pick < 90) begin
            b.command = CMD_RFE;
        end else if (pick < 97) begin
            b.command = CMD_ERET;
        end else begin
            b.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
        end
        b.register_index = ($urandom_range(0, 1) != 0) ? NAMED_REGS[$urandom_range(0, 9)]
                                                      : 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            b.write_data = '0;
        end else if (pick == 1) begin
            b.write_data = '1;
        end else if (pick < 4) begin
            b.write_data = 32'($urandom_range(0, 4095));
        end else begin
            b.write_data = $urandom();
        end
        b.tick_count     = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 255)) : $urandom();
        b.exception_code = ($urandom_range(0, 9) < 3) ? 5'($urandom_range(EXC_MOD, EXC_ADES))
                                                      : 5'($urandom_range(0, 31));
        b.current_pc     = $urandom();
        return b;
    endfunction

    task automatic cp0_reset();
        foreach (cp0_regs[k]) begin
            cp0_regs[k] = '0;
        end
        cp0_regs[R_PRID]    = RST_PRID;
        cp0_regs[R_CONFIG]  = RST_CONFIG;
        cp0_regs[R_STATUS]  = RST_STATUS;
        cp0_regs[R_COMPARE] = RST_COMPARE;
        cp0_regs[R_RANDOM]  = RST_RANDOM;
    endtask

    function automatic t_out_beat cp0_apply(input t_in_beat b);
        t_out_beat   r;
        logic [31:0] st;
        r  = '0;
        st = cp0_regs[R_STATUS];
        case (b.command)
            CMD_READ: begin
                r.read_data = cp0_regs[b.register_index];
            end
            CMD_WRITE: begin
                if (b.register_index == R_STATUS) begin
                    cp0_regs[R_STATUS] = (b.write_data & STATUS_WR_MASK) | (st & STATUS_KEEP);
                end else if (b.register_index == R_CAUSE) begin
                    cp0_regs[R_CAUSE] = (cp0_regs[R_CAUSE] & ~CAUSE_WR_MASK)
                                      | (b.write_data & CAUSE_WR_MASK);
                end else if (b.register_index != R_PRID && b.register_index != R_CONFIG) begin
                    cp0_regs[b.register_index] = b.write_data;
                end
            end
            CMD_TICK: begin
                cp0_regs[R_COUNT] = cp0_regs[R_COUNT] + b.tick_count;
                if (cp0_regs[R_COUNT] >= cp0_regs[R_COMPARE]) begin
                    cp0_regs[R_CAUSE] = cp0_regs[R_CAUSE] | CAUSE_TI;
                end
            end
            CMD_EXCEPTION: begin
                if ((st & ST_EXL) != 0) begin
                    cp0_regs[R_ERROREPC] = b.current_pc;
                end else begin
                    cp0_regs[R_EPC] = b.current_pc;
                end
                st = st | ST_EXL;
                cp0_regs[R_STATUS] = st;
                cp0_regs[R_CAUSE]  = (cp0_regs[R_CAUSE] & ~CAUSE_EXC_MASK)
                                   | {25'd0, b.exception_code, 2'b00};
                if (b.exception_code >= EXC_MOD && b.exception_code <= EXC_ADES) begin
                    cp0_regs[R_BADVADDR] = b.current_pc;
                end
                r.new_pc   = (((st & ST_BEV) != 0) ? VEC_BEV : VEC_NORMAL)
                           + {20'd0, b.exception_code, 7'd0};
                r.pc_valid = 1'b1;
            end
            CMD_RFE: begin
                cp0_regs[R_STATUS] = st & ~ST_EXL;
            end
            CMD_ERET: begin
                if ((st & ST_ERL) != 0) begin
                    r.new_pc           = cp0_regs[R_ERROREPC];
                    cp0_regs[R_STATUS] = st & ~ST_ERL;
                end else begin
                    r.new_pc           = cp0_regs[R_EPC];
                    cp0_regs[R_STATUS] = st & ~ST_EXL;
                end
                r.pc_valid = 1'b1;
            end
            default: begin
            end
        endcase
        st = cp0_regs[R_STATUS];
        if ((st & ST_IE) != 0) begin
            r.pending_irq = cp0_regs[R_CAUSE][15:8] & st[15:8];
        end
        return r;
    endfunction

    // Driver: predict on each accepted beat, then offer the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_beat  <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_results.push_back(cp0_apply(i_in_beat));
            end
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_beat  <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed by the stimulus process.
    always @(posedge i_clk) begin
        hold_arm_q <= hold_arm;
        if (hold_arm && !hold_arm_q) begin
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) begin
                    $display("ERROR: unexpected result beat %p", o_out_beat);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_out_beat.read_data !== want.read_data || o_out_beat.new_pc !== want.new_pc
                    || o_out_beat.pc_valid !== want.pc_valid
                    || o_out_beat.pending_irq !== want.pending_irq) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) begin
                        $display("ERROR: result mismatch expected %p got %p", want, o_out_beat);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        cp0_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_cmds.push_back(make_cmd(CMD_READ, R_PRID, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, R_CONFIG, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, R_RANDOM, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, R_COMPARE, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_STATUS, '1, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, R_STATUS, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_CAUSE, '1, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_PRID, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_CONFIG, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, R_CAUSE, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_EXCEPTION, '0, '0, '0, '1, 32'hFFFF_FFFC));
        pending_cmds.push_back(make_cmd(CMD_ERET, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_ERET, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_EXCEPTION, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_RFE, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_STATUS, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_EXCEPTION, '0, '0, '0, EXC_ADEL, 32'h1234_5678));
        pending_cmds.push_back(make_cmd(CMD_READ, R_BADVADDR, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, R_COMPARE, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TICK, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TICK, '0, '0, '1, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_SPARE_LO, '1, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(CMD_SPARE_HI, '0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, REG_LAST, '1, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_READ, REG_LAST, '0, '0, '0, '0));
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == PHASE_COUNT - 1) begin
                hold_arm = 1'b1;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                pending_cmds.push_back(random_cmd());
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mscp_pkg.sv
sv/mscp_ctrl.sv
sv/mscp_datapath.sv
sv/mips_system_coprocessor.sv
verif/tb_mips_system_coprocessor.sv
